@@ src/raw_sbp_pkg.sv @@
// Shared types and constants of the raw sector burst planner.
`timescale 1ns / 1ps
package raw_sbp_pkg;

    // Frame and block geometry
    localparam int FRAME_BYTES = 2352;
    localparam int BLOCK_SHIFT = 11;            // 2048-byte logical blocks

    // Start division: start_block * 128 / 147 by reciprocal multiplication,
    // staged as product, then quotient, then remainder
    localparam int DIV_DIVISOR = 147;
    localparam int DIV_RECIP   = 116869859;     // ceiling of 2^34 / 147
    localparam int DIV_SHIFT   = 27;            // 34 less the factor of 128
    localparam int DIV_PROD_W  = 47;
    localparam int DIV_STEPS   = 3;
    localparam int DIV_CNT_W   = 2;

    // Ceiling of a 16-bit value over 147 by reciprocal multiplication
    localparam int CEIL_BIAS   = 146;
    localparam int CEIL_RECIP  = 114131;
    localparam int CEIL_SHIFT  = 24;
    localparam int CEIL_PROD_W = 33;

    // Results per request
    localparam int RESULT_MAX  = 16;
    localparam int BEAT_CNT_W  = 4;

    // Result kinds
    localparam logic KIND_BURST   = 1'b0;
    localparam logic KIND_REFUSED = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ENABLED      = 2'd0,
        CFG_TRACK_START  = 2'd1,
        CFG_TRACK_LENGTH = 2'd2
    } t_cfg_idx;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_SIZE,
        S_TRIM,
        S_BURST,
        S_REFUSE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic take;
        logic div_step;
        logic check;
        logic size;
        logic trim;
        logic emit_burst;
        logic emit_refuse;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic div_last;
        logic refuse;
        logic fin;
        logic out_free;
    } t_status;

endpackage

@@ src/raw_sbp_ctrl.sv @@
// Sequencing state machine of the raw sector burst planner.
`timescale 1ns / 1ps
module raw_sbp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  raw_sbp_pkg::t_status i_status,
    output raw_sbp_pkg::t_cmd    o_cmd
);
    import raw_sbp_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_SIZE;
            end
            S_SIZE: begin
                if (i_status.refuse) begin
                    n_state = S_REFUSE;
                end else begin
                    o_cmd.size = 1'b1;
                    n_state    = S_TRIM;
                end
            end
            S_TRIM: begin
                o_cmd.trim = 1'b1;
                n_state    = S_BURST;
            end
            S_BURST: begin
                // one burst beat per free output slot
                if (i_status.out_free) begin
                    o_cmd.emit_burst = 1'b1;
                    if (i_status.fin) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_REFUSE: begin
                if (i_status.out_free) begin
                    o_cmd.emit_refuse = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/raw_sbp_dp.sv @@
// Datapath of the raw sector burst planner: config, divider, burst arithmetic, output.
`timescale 1ns / 1ps
module raw_sbp_dp #(
    parameter int BURST_FRAMES = 16,
    parameter int MAX_BLOCKS   = 255
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  raw_sbp_pkg::t_cmd    i_cmd,
    output raw_sbp_pkg::t_status o_status,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [18:0]          i_cfg_data,
    input  logic [19:0]          i_start_block,
    input  logic [7:0]           i_block_count,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic                 o_kind,
    output logic [19:0]          o_disc_sector,
    output logic [4:0]           o_frame_count,
    output logic [11:0]          o_skip_bytes,
    output logic [18:0]          o_dest_offset,
    output logic [15:0]          o_byte_count,
    output logic [18:0]          o_tail_zero_bytes,
    output logic                 o_last
);
    import raw_sbp_pkg::*;

    localparam int FRW = $clog2(BURST_FRAMES + 1);
    localparam int FXW = (FRW > 5) ? FRW : 5;
    localparam int AVW = $clog2(BURST_FRAMES * FRAME_BYTES + 1);
    localparam int CW  = (AVW > 19) ? AVW : 19;
    localparam logic [8:0] BURST_LIM = 9'(BURST_FRAMES);

    // Configuration
    logic        r_enabled;
    logic [18:0] r_track_start;
    logic [18:0] r_track_length;

    // Divider
    logic [19:0]           r_dvd;
    logic [DIV_PROD_W-1:0] r_prod;
    logic [7:0]            r_rem;
    logic [19:0]           r_quo;
    logic [DIV_CNT_W-1:0]  r_div_cnt;
    logic [7:0]            r_count;

    // Request setup
    logic                   r_refuse;
    logic [18:0]            r_room;
    logic [CEIL_PROD_W-1:0] r_ceil_prod;
    logic [30:0]            r_img_bytes;

    // Burst walk
    logic [8:0]            r_rem_frames;
    logic [18:0]           r_left;
    logic [18:0]           r_tail;
    logic [19:0]           r_frame;
    logic [11:0]           r_off;
    logic [18:0]           r_dest;
    logic [BEAT_CNT_W-1:0] r_beat_cnt;

    // Output register
    logic        r_out_valid;
    logic        r_kind;
    logic [19:0] r_disc_sector;
    logic [4:0]  r_frame_count;
    logic [11:0] r_skip_bytes;
    logic [18:0] r_dest_offset;
    logic [15:0] r_byte_count;
    logic [18:0] r_tail_zero;
    logic        r_last;

    // Combinational terms
    logic [11:0]            off0;
    logic                   refuse_now;
    logic [15:0]            ceil_arg;
    logic [CEIL_PROD_W-1:0] ceil_prod;
    logic [8:0]             f_need;
    logic [30:0]            rem_img;
    logic [30:0]            want;
    logic [8:0]             frames_all;
    logic [FRW-1:0]         frames;
    logic [FXW-1:0]         frames_x;
    logic [AVW-1:0]         avail;
    logic                   left_fits;
    logic [18:0]            beat_n;
    logic                   fin;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled      <= 1'b0;
            r_track_start  <= '0;
            r_track_length <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLED:      r_enabled      <= i_cfg_data[0];
                CFG_TRACK_START:  r_track_start  <= i_cfg_data;
                CFG_TRACK_LENGTH: r_track_length <= i_cfg_data;
                default:          r_enabled      <= r_enabled;
            endcase
        end
    end

    // Request checks and frame counts
    always_comb begin
        off0       = {r_rem, 4'b0000};
        refuse_now = !r_enabled || (r_count == 8'd0) || (r_count > 8'(MAX_BLOCKS))
                     || (r_quo >= {1'b0, r_track_length});
        ceil_arg   = {1'b0, r_count, 7'b0} + 16'(r_rem) + 16'(CEIL_BIAS);
        ceil_prod  = CEIL_PROD_W'(ceil_arg) * CEIL_PROD_W'(CEIL_RECIP);
        f_need     = r_ceil_prod[CEIL_SHIFT +: 9];
        rem_img    = r_img_bytes - 31'(off0);
        want       = 31'({r_count, 11'b0});
    end

    // Current burst
    always_comb begin
        frames_all = (r_rem_frames < BURST_LIM) ? r_rem_frames : BURST_LIM;
        frames     = frames_all[FRW-1:0];
        frames_x   = FXW'(frames);
        avail      = AVW'(frames) * AVW'(FRAME_BYTES) - AVW'(r_off);
        left_fits  = (CW'(r_left) <= CW'(avail));
        beat_n     = left_fits ? r_left : 19'(avail);
        fin        = left_fits || (r_beat_cnt == BEAT_CNT_W'(RESULT_MAX - 1));
    end

    // Divider and setup registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_dvd     <= i_start_block;
            r_div_cnt <= '0;
            r_count   <= i_block_count;
        end else if (i_cmd.div_step) begin
            // product, then quotient, then remainder: one stage a cycle
            r_prod    <= DIV_PROD_W'(r_dvd) * DIV_PROD_W'(DIV_RECIP);
            r_quo     <= r_prod[DIV_SHIFT +: 20];
            r_rem     <= {r_dvd[0], 7'b0} - 8'(r_quo[7:0] * 8'(DIV_DIVISOR));
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        if (i_cmd.check) begin
            r_refuse    <= refuse_now;
            r_room      <= r_track_length - r_quo[18:0];
            r_ceil_prod <= ceil_prod;
        end
    end

    // Burst walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.size) begin
            r_rem_frames <= (19'(f_need) < r_room) ? f_need : r_room[8:0];
            r_img_bytes  <= 31'(r_room) * 31'(FRAME_BYTES);
        end
        if (i_cmd.trim) begin
            if (want > rem_img) begin
                r_tail <= 19'(want - rem_img);
                r_left <= rem_img[18:0];
            end else begin
                r_tail <= '0;
                r_left <= want[18:0];
            end
            r_frame    <= r_quo;
            r_off      <= off0;
            r_dest     <= '0;
            r_beat_cnt <= '0;
        end else if (i_cmd.emit_burst) begin
            // advance to the next whole frame
            r_frame      <= r_frame + 20'(frames);
            r_off        <= '0;
            r_left       <= r_left - beat_n;
            r_dest       <= r_dest + beat_n;
            r_rem_frames <= r_rem_frames - 9'(frames);
            r_beat_cnt   <= r_beat_cnt + 1'b1;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_burst || i_cmd.emit_refuse) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_burst) begin
            r_kind        <= KIND_BURST;
            r_disc_sector <= 20'(r_track_start) + r_frame;
            r_frame_count <= frames_x[4:0];
            r_skip_bytes  <= r_off;
            r_dest_offset <= r_dest;
            r_byte_count  <= beat_n[15:0];
            r_tail_zero   <= fin ? r_tail : 19'd0;
            r_last        <= fin;
        end else if (i_cmd.emit_refuse) begin
            r_kind        <= KIND_REFUSED;
            r_disc_sector <= '0;
            r_frame_count <= '0;
            r_skip_bytes  <= '0;
            r_dest_offset <= '0;
            r_byte_count  <= '0;
            r_tail_zero   <= '0;
            r_last        <= 1'b1;
        end
    end

    // Status to the controller
    always_comb begin
        o_status.div_last = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
        o_status.refuse   = r_refuse;
        o_status.fin      = fin;
        o_status.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_kind;
    assign o_disc_sector     = r_disc_sector;
    assign o_frame_count     = r_frame_count;
    assign o_skip_bytes      = r_skip_bytes;
    assign o_dest_offset     = r_dest_offset;
    assign o_byte_count      = r_byte_count;
    assign o_tail_zero_bytes = r_tail_zero;
    assign o_last            = r_last;

endmodule

@@ src/raw_sector_burst_planner_top.sv @@
// Sequence: a taken request runs the reciprocal divide by 147 (product, quotient, remainder),
// then the check, size and trim setup states, before its first result is registered; a refusal
// goes from the size state to its result without trim. Throughput: one burst result per cycle
// after that while the output is not stalled; the next request is taken in the cycle after the
// final result is loaded.
// Reset (synchronous, active low) clears the configuration, the controller and output valid.
`timescale 1ns / 1ps
module raw_sector_burst_planner_top #(
    parameter int BURST_FRAMES = 16,
    parameter int MAX_BLOCKS   = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [18:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [19:0] i_start_block,
    input  logic [7:0]  i_block_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [19:0] o_disc_sector,
    output logic [4:0]  o_frame_count,
    output logic [11:0] o_skip_bytes,
    output logic [18:0] o_dest_offset,
    output logic [15:0] o_byte_count,
    output logic [18:0] o_tail_zero_bytes,
    output logic        o_last
);
    import raw_sbp_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer
    raw_sbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Arithmetic and output register
    raw_sbp_dp #(
        .BURST_FRAMES (BURST_FRAMES),
        .MAX_BLOCKS   (MAX_BLOCKS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_start_block     (i_start_block),
        .i_block_count     (i_block_count),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_kind            (o_kind),
        .o_disc_sector     (o_disc_sector),
        .o_frame_count     (o_frame_count),
        .o_skip_bytes      (o_skip_bytes),
        .o_dest_offset     (o_dest_offset),
        .o_byte_count      (o_byte_count),
        .o_tail_zero_bytes (o_tail_zero_bytes),
        .o_last            (o_last)
    );

endmodule

@@ verif/tb_raw_sector_burst_planner_top.sv @@
// Self-checking testbench for the raw sector burst planner: request stimulus, burst scoreboard.
`timescale 1ns / 1ps

module tb_raw_sector_burst_planner_top;
    import raw_sbp_pkg::*;

    // One result beat as it leaves the planner
    typedef struct packed {
        logic        kind;
        logic [19:0] disc_sector;
        logic [4:0]  frame_count;
        logic [11:0] skip_bytes;
        logic [18:0] dest_offset;
        logic [15:0] byte_count;
        logic [18:0] tail_zero_bytes;
        logic        last;
    } t_burst_beat;

    // Plans the bursts of each accepted request and checks result beats against them
    class sector_plan_board;
        int unsigned burst_frames;
        int unsigned max_blocks;
        bit          enabled;
        bit [18:0]   track_start;
        bit [18:0]   track_length;
        t_burst_beat planned[$];
        int unsigned mismatches;

        function new(int unsigned burst_frames_p, int unsigned max_blocks_p);
            burst_frames = burst_frames_p;
            max_blocks   = max_blocks_p;
            enabled      = 1'b0;
            track_start  = '0;
            track_length = '0;
            mismatches   = 0;
        endfunction

        // Mirror a register write into the local copy of the configuration
        function void write_reg(t_cfg_idx idx, logic [18:0] data);
            case (idx)
                CFG_ENABLED:      enabled      = data[0];
                CFG_TRACK_START:  track_start  = data;
                CFG_TRACK_LENGTH: track_length = data;
                default: ;
            endcase
        endfunction

        // Work out every burst beat that an accepted request causes
        function void plan_request(logic [19:0] start, logic [7:0] count);
            longint unsigned size, b0, b1, tail, b, frame, off, room, need;
            longint unsigned frames, avail, want, n;
            int              k;
            t_burst_beat     beat;
            size = 64'(track_length) * 64'(FRAME_BYTES);
            b0   = 64'(start) << BLOCK_SHIFT;
            b1   = b0 + (64'(count) << BLOCK_SHIFT);
            tail = 0;
            beat = '0;
            // Refuse: disabled, empty request, too long, or starting past the image
            if (!enabled || count == 0 || count > max_blocks || b0 >= size) begin
                beat.kind = KIND_REFUSED;
                beat.last = 1'b1;
                planned.push_back(beat);
                return;
            end
            // Clip to the image end; the remainder is zero-filled
            if (b1 > size) begin
                tail = b1 - size;
                b1   = size;
            end
            b = b0;
            k = 0;
            while (b < b1 && k < RESULT_MAX) begin
                frame  = b / FRAME_BYTES;
                off    = b % FRAME_BYTES;
                room   = 64'(track_length) - frame;
                need   = b1 - b + off;
                frames = (need + FRAME_BYTES - 1) / FRAME_BYTES;
                if (frames > room) frames = room;
                if (frames > burst_frames) frames = burst_frames;
                if (frames < 1) frames = 1;
                avail = frames * FRAME_BYTES - off;
                want  = b1 - b;
                n     = (avail < want) ? avail : want;
                beat.kind            = KIND_BURST;
                beat.disc_sector     = 20'(64'(track_start) + frame);
                beat.frame_count     = 5'(frames);
                beat.skip_bytes      = 12'(off);
                beat.dest_offset     = 19'(b - b0);
                beat.byte_count      = 16'(n);
                beat.last            = (b + n >= b1) || (k == RESULT_MAX - 1);
                beat.tail_zero_bytes = beat.last ? 19'(tail) : '0;
                planned.push_back(beat);
                k++;
                b += n;
            end
        endfunction

        function void compare_field(string field, logic [63:0] exp_v, logic [63:0] got_v);
            if (got_v !== exp_v) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: %s expected %0d, got %0d", $time, field, exp_v, got_v);
            end
        endfunction

        // Compare one accepted beat with the oldest planned one
        function void check_beat(t_burst_beat seen);
            t_burst_beat want;
            if (planned.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unplanned beat %p", $time, seen);
                return;
            end
            want = planned.pop_front();
            compare_field("kind", want.kind, seen.kind);
            compare_field("disc_sector", want.disc_sector, seen.disc_sector);
            compare_field("frame_count", want.frame_count, seen.frame_count);
            compare_field("skip_bytes", want.skip_bytes, seen.skip_bytes);
            compare_field("dest_offset", want.dest_offset, seen.dest_offset);
            compare_field("byte_count", want.byte_count, seen.byte_count);
            compare_field("tail_zero_bytes", want.tail_zero_bytes, seen.tail_zero_bytes);
            compare_field("last", want.last, seen.last);
        endfunction
    endclass

    localparam int BURST_FRAMES  = 16;
    localparam int MAX_BLOCKS    = 255;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 34;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [18:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [19:0] i_start_block;
    logic [7:0]  i_block_count;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_kind;
    logic [19:0] o_disc_sector;
    logic [4:0]  o_frame_count;
    logic [11:0] o_skip_bytes;
    logic [18:0] o_dest_offset;
    logic [15:0] o_byte_count;
    logic [18:0] o_tail_zero_bytes;
    logic        o_last;

    sector_plan_board planner;
    bit               calm;
    bit               rushing;
    bit               hold_req;
    int unsigned      cycle_count;

    raw_sector_burst_planner_top #(
        .BURST_FRAMES(BURST_FRAMES),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_start_block    (i_start_block),
        .i_block_count    (i_block_count),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_disc_sector    (o_disc_sector),
        .o_frame_count    (o_frame_count),
        .o_skip_bytes     (o_skip_bytes),
        .o_dest_offset    (o_dest_offset),
        .o_byte_count     (o_byte_count),
        .o_tail_zero_bytes(o_tail_zero_bytes),
        .o_last           (o_last)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic hold_stall(input logic level, input int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_out_stall <= level;
        end
    endtask

    // Offer one request beat, hold it until taken, then idle for a random gap that may be zero
    task automatic send_request(input logic [19:0] start, input logic [7:0] count);
        int unsigned gap;
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_start_block <= start;
        i_block_count <= count;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        planner.plan_request(start, count);
        gap = (calm || rushing) ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drop valid, wait for every planned beat, then let the pipeline settle
    task automatic drain_and_settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (planner.planned.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [18:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        planner.write_reg(idx, data);
    endtask

    // Reprogramme all three registers once the block is idle
    task automatic configure(input logic en, input logic [18:0] ts, input logic [18:0] tl);
        logic [17:0] junk;
        junk = 18'($urandom);
        drain_and_settle();
        write_reg(CFG_ENABLED, {junk, en});
        write_reg(CFG_TRACK_START, ts);
        write_reg(CFG_TRACK_LENGTH, tl);
    endtask

    function automatic logic [18:0] pick_track_length(input int p);
        int unsigned r;
        if (p == 0) return 19'd524287;
        if (p == 1) return 19'd1;
        if (p == 2) return 19'd2;
        if (p == 7) return 19'd0;
        r = $urandom_range(9, 0);
        if (r < 5) return 19'($urandom_range(300, 1));
        if (r < 8) return 19'($urandom_range(20000, 301));
        return 19'($urandom_range(524287, 20001));
    endfunction

    // Mostly requests inside the image, some near its end, a few anywhere
    function automatic void pick_request(input logic [18:0] tl, output logic [19:0] start,
                                         output logic [7:0] count);
        longint unsigned size;
        int unsigned     last_blk, span, r;
        size     = 64'(tl) * 64'(FRAME_BYTES);
        last_blk = (size == 0) ? 0 : int'((size - 1) >> BLOCK_SHIFT);
        span     = (last_blk < 300) ? last_blk : 300;
        r        = $urandom_range(99, 0);
        if (r < 70)
            start = 20'($urandom_range(last_blk, 0));
        else if (r < 85)
            start = 20'(last_blk - $urandom_range(span, 0));
        else
            start = 20'($urandom);
        r = $urandom_range(99, 0);
        if (r < 10)      count = 8'($urandom_range(4, 1));
        else if (r < 80) count = 8'($urandom_range(255, 1));
        else if (r < 88) count = 8'd255;
        else if (r < 93) count = 8'd0;
        else             count = 8'($urandom_range(255, 0));
    endfunction

    // Result side: random stalls, quiet stretches, and one long hold-off on request
    initial begin : result_sink
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                hold_stall(1'b1, HOLD_CYCLES);
            end else if (calm) begin
                hold_stall(1'b0, 1);
            end else begin
                hold_stall(1'b0, $urandom_range(12, 1));
                hold_stall(1'b1, pick_gap());
            end
        end
    end

    // Check every accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            planner.check_beat(t_burst_beat'{o_kind, o_disc_sector, o_frame_count,
                o_skip_bytes, o_dest_offset, o_byte_count, o_tail_zero_bytes, o_last});
    end

    // Guard against a hang
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[raw_sector_burst_planner_top] ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [18:0] ts, tl;
        logic [19:0] start;
        logic [7:0]  count;
        planner       = new(BURST_FRAMES, MAX_BLOCKS);
        calm          = 1'b0;
        rushing       = 1'b0;
        hold_req      = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_ENABLED;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_start_block = '0;
        i_block_count = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Disabled straight after reset, then an empty track
        send_request(20'd0, 8'd1);
        configure(1'b1, 19'd0, 19'd0);
        send_request(20'd0, 8'd1);

        // Mid-sized track: offsets, zero count, tails, starts past the end
        configure(1'b1, 19'd150, 19'd1000);
        send_request(20'd0, 8'd1);
        send_request(20'd0, 8'd255);
        send_request(20'd0, 8'd0);
        send_request(20'd3, 8'd5);
        send_request(20'd1148, 8'd1);
        send_request(20'd1148, 8'd255);
        send_request(20'd1149, 8'd1);
        send_request(20'd1048575, 8'd255);
        send_request(20'd524288, 8'd3);
        send_request(20'd1000, 8'd200);

        // Image size a whole number of blocks: requests ending exactly at the end
        configure(1'b1, 19'd37, 19'd128);
        send_request(20'd146, 8'd1);
        send_request(20'd140, 8'd7);
        send_request(20'd140, 8'd8);
        send_request(20'd147, 8'd1);

        // Largest track at the highest start sector
        configure(1'b1, 19'd524287, 19'd524287);
        send_request(20'd0, 8'd255);
        send_request(20'd602110, 8'd255);
        send_request(20'd602111, 8'd1);
        send_request(20'd602110, 8'd1);

        // Single-frame track: a block straddling the end
        configure(1'b1, 19'd9, 19'd1);
        send_request(20'd0, 8'd2);
        send_request(20'd1, 8'd1);
        send_request(20'd2, 8'd1);

        // Random phases over a spread of settings
        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0:       ts = 19'd0;
                1:       ts = 19'd524287;
                default: ts = 19'($urandom);
            endcase
            tl = pick_track_length(p);
            configure((p == 5) ? 1'b0 : 1'b1, ts, tl);
            calm = (p == 3 || p == 8);
            if (p == 6) begin
                rushing  = 1'b1;
                hold_req = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pick_request(tl, start, count);
                send_request(start, count);
            end
            calm    = 1'b0;
            rushing = 1'b0;
        end

        drain_and_settle();
        if (planner.mismatches == 0 && planner.planned.size() == 0)
            $display("[raw_sector_burst_planner_top] OK");
        else
            $display("[raw_sector_burst_planner_top] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
src/raw_sbp_pkg.sv
src/raw_sbp_ctrl.sv
src/raw_sbp_dp.sv
src/raw_sector_burst_planner_top.sv
verif/tb_raw_sector_burst_planner_top.sv
